/* src/sensor_frame_crc_check_convert_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the sensor frame CRC check and convert block
// Concurrent assertion wrappers, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef SENSOR_FRAME_CRC_CHECK_CONVERT_DEFINES_SVH
`define SENSOR_FRAME_CRC_CHECK_CONVERT_DEFINES_SVH

`ifndef ASSERT_OFF
// checked outside reset
`define SFCC_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// checked at every edge
`define SFCC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SFCC_ASSERT(lbl, clk, rst_n, prop, msg)
`define SFCC_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif

`endif

/* src/sfcc_pkg.sv */
// ----------------------------------------------------------------------------
// sfcc_pkg
// Shared types, constants and the CRC-8 byte step for the frame converter.
// ----------------------------------------------------------------------------
package sfcc_pkg;

  localparam int unsigned CFG_IDX_W = 8;
  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int unsigned Q_CNT_W   = $clog2(Q_DEPTH + 1);

  localparam logic [2:0] FRAME_BYTES = 3'd6;
  localparam logic [2:0] CRC_POS_T   = 3'd2;
  localparam logic [2:0] CRC_POS_H   = 3'd5;
  localparam logic [7:0] CRC_INIT    = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h31;

  // Q8 spans: 175 * 256 and 100 * 256, offset 45 * 256
  localparam logic [15:0]        TEMP_SPAN  = 16'd44800;
  localparam logic [15:0]        HUM_SPAN   = 16'd25600;
  localparam logic [31:0]        RAW_HALF   = 32'd32767;
  localparam logic [16:0]        RAW_FULL   = 17'd65535;
  localparam logic signed [16:0] TEMP_BASE  = 17'sd11520;
  localparam logic signed [33:0] CAL_ROUND  = 34'sd8192;
  localparam int unsigned        CAL_SHIFT  = 14;
  localparam logic [15:0]        GAIN_ONE   = 16'd16384;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TEMP_GAIN   = 8'd0,
    REG_TEMP_OFFSET = 8'd1,
    REG_HUM_GAIN    = 8'd2,
    REG_HUM_OFFSET  = 8'd3
  } sfcc_reg_t;

  typedef struct packed {
    logic [15:0]        temp_gain;
    logic signed [15:0] temp_offset;
    logic [15:0]        hum_gain;
    logic signed [15:0] hum_offset;
  } sfcc_cfg_t;

  typedef struct packed {
    logic [15:0] temp_word;
    logic [15:0] hum_word;
    logic        ok;
  } sfcc_frame_t;

  typedef struct packed {
    logic full;
    logic empty;
  } sfcc_q_stat_t;

  typedef enum logic [2:0] {
    BS_IDLE,
    BS_MUL,
    BS_DIV,
    BS_GAIN,
    BS_DONE
  } sfcc_bst_t;

  // CRC-8, MSB first, no reflection
  function automatic logic [7:0] crc_step(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* src/sfcc_if.sv */
// ----------------------------------------------------------------------------
// sfcc channel interfaces
// Valid/ready channels for sensor bytes, results and register writes.
// ----------------------------------------------------------------------------
interface sfcc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       frame_end;
  modport source(output valid, rx_byte, frame_end, input ready);
  modport sink(input valid, rx_byte, frame_end, output ready);
endinterface

interface sfcc_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] temperature_q8;
  logic signed [15:0] humidity_q8;
  logic               frame_ok;
  modport source(output valid, temperature_q8, humidity_q8, frame_ok, input ready);
  modport sink(input valid, temperature_q8, humidity_q8, frame_ok, output ready);
endinterface

interface sfcc_cfg_if;
  import sfcc_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [15:0]          data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* src/sensor_frame_crc_check_convert.sv */
// ----------------------------------------------------------------------------
// sensor_frame_crc_check_convert
// Checks a six-byte humidity/temperature sensor frame and converts it to Q8.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch  : one sensor byte per item (rx_byte, frame_end). A frame is
//            temp hi, temp lo, CRC, hum hi, hum lo, CRC (CRC-8 poly 0x31,
//            init 0xFF per word). frame_end on an earlier byte ends it short.
//   out_ch : one item per frame: temperature_q8, humidity_q8 (signed Q8,
//            calibrated, saturated) and frame_ok. Short frame or CRC error
//            gives zeros with frame_ok low.
//   cfg_ch : register writes, index 0..3 = temp_gain, temp_offset, hum_gain,
//            hum_offset; other indexes are dropped. Always ready.
// Throughput: one byte per cycle into the front while the queue is not full;
//   the back converter takes one frame at a time through queue pop, multiply,
//   divide-by-65535, gain multiply, round and saturate. Short frames sent
//   back to back outpace it, and in_ch.ready then drops.
// Reset: frame state cleared, gains 1.0, offsets 0, queue and output empty.
// Stall: the output register holds while out_ch.ready is low; frames build
//   up in a 2-deep queue, then in_ch.ready drops until space frees up.
// ----------------------------------------------------------------------------
`include "sensor_frame_crc_check_convert_defines.svh"

module sensor_frame_crc_check_convert (
  input  logic       clk,
  input  logic       rst_n,
  sfcc_in_if.sink    in_ch,
  sfcc_out_if.source out_ch,
  sfcc_cfg_if.sink   cfg_ch
);
  import sfcc_pkg::*;

  sfcc_cfg_t    cfg_r, cfg_nxt;
  sfcc_q_stat_t q_stat;
  sfcc_frame_t  q_push_data;
  sfcc_frame_t  q_head;
  logic         q_push;
  logic         q_pop;

  // register file: writes land in the next cycle, never stalled
  assign cfg_ch.ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_TEMP_GAIN:   cfg_nxt.temp_gain   = cfg_ch.data;
        REG_TEMP_OFFSET: cfg_nxt.temp_offset = signed'(cfg_ch.data);
        REG_HUM_GAIN:    cfg_nxt.hum_gain    = cfg_ch.data;
        REG_HUM_OFFSET:  cfg_nxt.hum_offset  = signed'(cfg_ch.data);
        default:         cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.temp_gain   <= GAIN_ONE;
      cfg_r.temp_offset <= '0;
      cfg_r.hum_gain    <= GAIN_ONE;
      cfg_r.hum_offset  <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // front: byte tracking and CRC checks
  sfcc_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_stat (q_stat),
    .q_push (q_push),
    .q_data (q_push_data)
  );

  // frame queue decouples byte intake from conversion
  sfcc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  // back: conversion and output register
  sfcc_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .q_stat (q_stat),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

  // a completed frame must always find room in the queue
  `SFCC_ASSERT(a_push_room, clk, rst_n, q_push |-> !q_stat.full, "frame pushed into full queue")
  // the converter only starts on a queued frame
  `SFCC_ASSERT(a_pop_data, clk, rst_n, q_pop |-> !q_stat.empty, "pop from empty queue")
  // failed frames carry zero readings
  `SFCC_ASSERT(a_fail_zero, clk, rst_n,
    (out_ch.valid && !out_ch.frame_ok) |->
      (out_ch.temperature_q8 == 16'sd0 && out_ch.humidity_q8 == 16'sd0),
    "failed frame with nonzero reading")

endmodule

/* src/sfcc_front.sv */
// ----------------------------------------------------------------------------
// sfcc_front
// Byte assembler: tracks frame position, checks both CRCs, queues frames.
// ----------------------------------------------------------------------------
module sfcc_front (
  input  logic                 clk,
  input  logic                 rst_n,
  sfcc_in_if.sink              in_ch,
  input  sfcc_pkg::sfcc_q_stat_t q_stat,
  output logic                 q_push,
  output sfcc_pkg::sfcc_frame_t  q_data
);
  import sfcc_pkg::*;

  logic [2:0]  pos_r,  pos_nxt;
  logic [7:0]  crc_r,  crc_nxt;
  logic [15:0] tw_r,   tw_nxt;
  logic [15:0] hw_r,   hw_nxt;
  logic        good_r, good_nxt;

  logic        take;
  logic        is_crc;
  logic [2:0]  pos_inc;
  logic        frame_done;

  assign in_ch.ready = !q_stat.full;
  assign take        = in_ch.valid && in_ch.ready;
  assign is_crc      = (pos_r == CRC_POS_T) || (pos_r == CRC_POS_H);
  assign pos_inc     = pos_r + 3'd1;
  assign frame_done  = (pos_inc == FRAME_BYTES) || in_ch.frame_end;

  always_comb begin
    pos_nxt  = pos_r;
    crc_nxt  = crc_r;
    tw_nxt   = tw_r;
    hw_nxt   = hw_r;
    good_nxt = good_r;
    q_push   = 1'b0;
    q_data   = '0;
    if (take) begin
      if (is_crc) begin
        if (crc_r != in_ch.rx_byte) begin
          good_nxt = 1'b0;
        end
        crc_nxt = CRC_INIT;
      end else begin
        crc_nxt = crc_step(crc_r, in_ch.rx_byte);
        if (pos_r < CRC_POS_T) begin
          tw_nxt = {tw_r[7:0], in_ch.rx_byte};
        end else begin
          hw_nxt = {hw_r[7:0], in_ch.rx_byte};
        end
      end
      pos_nxt = pos_inc;
      if (frame_done) begin
        q_push         = 1'b1;
        q_data.temp_word = tw_nxt;
        q_data.hum_word  = hw_nxt;
        q_data.ok        = (pos_inc == FRAME_BYTES) && good_nxt;
        pos_nxt  = '0;
        crc_nxt  = CRC_INIT;
        tw_nxt   = '0;
        hw_nxt   = '0;
        good_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      crc_r  <= CRC_INIT;
      tw_r   <= '0;
      hw_r   <= '0;
      good_r <= 1'b1;
    end else begin
      pos_r  <= pos_nxt;
      crc_r  <= crc_nxt;
      tw_r   <= tw_nxt;
      hw_r   <= hw_nxt;
      good_r <= good_nxt;
    end
  end

endmodule

/* src/sfcc_queue.sv */
// ----------------------------------------------------------------------------
// sfcc_queue
// Short register queue of assembled frames between front and back.
// ----------------------------------------------------------------------------
module sfcc_queue (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  sfcc_pkg::sfcc_frame_t  push_data,
  input  logic                   pop,
  output sfcc_pkg::sfcc_frame_t  head,
  output sfcc_pkg::sfcc_q_stat_t stat
);
  import sfcc_pkg::*;

  sfcc_frame_t        mem_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;
  logic               do_push, do_pop;

  assign stat.full  = (cnt_r == Q_CNT_W'(Q_DEPTH));
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head       = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (do_push) begin
      wp_nxt = (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + Q_PTR_W'(1);
    end
    if (do_pop) begin
      rp_nxt = (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + Q_PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + Q_CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - Q_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wp_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* src/sfcc_back.sv */
// ----------------------------------------------------------------------------
// sfcc_back
// Conversion sequencer: raw words to calibrated Q8 readings, output register.
// ----------------------------------------------------------------------------
module sfcc_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  sfcc_pkg::sfcc_cfg_t    cfg,
  input  sfcc_pkg::sfcc_q_stat_t q_stat,
  input  sfcc_pkg::sfcc_frame_t  q_head,
  output logic                   q_pop,
  sfcc_out_if.source             out_ch
);
  import sfcc_pkg::*;

  sfcc_bst_t          state_r, state_nxt;
  sfcc_frame_t        ent_r;
  logic [31:0]        xt_r, xh_r;
  logic signed [16:0] vt_r, vh_r;
  logic signed [33:0] pt_r, ph_r;
  logic               ovalid_r, ovalid_nxt;
  logic signed [15:0] otemp_r, ohum_r;
  logic               ook_r;

  logic               ld_mul, ld_div, ld_gain, ld_out;
  logic [16:0]        qt, qh;
  logic signed [15:0] cal_t, cal_h;

  // floor(x / 65535) with x = a*2^16 + b: a + (a + b >= 65535), exact here
  function automatic logic [16:0] div_full(input logic [31:0] x);
    logic [16:0] s;
    s = {1'b0, x[31:16]} + {1'b0, x[15:0]};
    return {1'b0, x[31:16]} + ((s >= RAW_FULL) ? 17'd1 : 17'd0);
  endfunction

  // round half up by 2^14, add offset, saturate to 16 bits
  function automatic logic signed [15:0] cal_sat(input logic signed [33:0] p,
                                                 input logic signed [15:0] off);
    logic signed [33:0] rnd;
    logic signed [20:0] sum;
    rnd = (p + CAL_ROUND) >>> CAL_SHIFT;
    sum = 21'(signed'(rnd[19:0])) + 21'(off);
    if (sum > 21'sd32767) begin
      return 16'sh7FFF;
    end else if (sum < -21'sd32768) begin
      return 16'sh8000;
    end else begin
      return sum[15:0];
    end
  endfunction

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BS_IDLE: begin
        if (!q_stat.empty) begin
          state_nxt = BS_MUL;
        end
      end
      BS_MUL:  state_nxt = BS_DIV;
      BS_DIV:  state_nxt = BS_GAIN;
      BS_GAIN: state_nxt = BS_DONE;
      BS_DONE: begin
        if (!ovalid_r || out_ch.ready) begin
          state_nxt = BS_IDLE;
        end
      end
      default: state_nxt = BS_IDLE;
    endcase
  end

  // per-state controls
  always_comb begin
    q_pop   = 1'b0;
    ld_mul  = 1'b0;
    ld_div  = 1'b0;
    ld_gain = 1'b0;
    ld_out  = 1'b0;
    case (state_r)
      BS_IDLE: q_pop   = !q_stat.empty;
      BS_MUL:  ld_mul  = 1'b1;
      BS_DIV:  ld_div  = 1'b1;
      BS_GAIN: ld_gain = 1'b1;
      BS_DONE: ld_out  = !ovalid_r || out_ch.ready;
      default: q_pop   = 1'b0;
    endcase
  end

  assign qt    = div_full(xt_r);
  assign qh    = div_full(xh_r);
  assign cal_t = cal_sat(pt_r, cfg.temp_offset);
  assign cal_h = cal_sat(ph_r, cfg.hum_offset);

  always_comb begin
    ovalid_nxt = ovalid_r;
    if (ld_out) begin
      ovalid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      ent_r <= q_head;
    end
    if (ld_mul) begin
      xt_r <= 32'(ent_r.temp_word) * 32'(TEMP_SPAN) + RAW_HALF;
      xh_r <= 32'(ent_r.hum_word) * 32'(HUM_SPAN) + RAW_HALF;
    end
    if (ld_div) begin
      vt_r <= signed'(qt) - TEMP_BASE;
      vh_r <= signed'(qh);
    end
    if (ld_gain) begin
      pt_r <= 34'(vt_r) * 34'(signed'({1'b0, cfg.temp_gain}));
      ph_r <= 34'(vh_r) * 34'(signed'({1'b0, cfg.hum_gain}));
    end
    if (ld_out) begin
      otemp_r <= ent_r.ok ? cal_t : '0;
      ohum_r  <= ent_r.ok ? cal_h : '0;
      ook_r   <= ent_r.ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= BS_IDLE;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  assign out_ch.valid          = ovalid_r;
  assign out_ch.temperature_q8 = otemp_r;
  assign out_ch.humidity_q8    = ohum_r;
  assign out_ch.frame_ok       = ook_r;

endmodule

/* tb/tb_sensor_frame_crc_check_convert.sv */
// ----------------------------------------------------------------------------
// tb_sensor_frame_crc_check_convert
// Self-checking bench for the six-byte sensor frame checker and Q8 converter.
// Sends whole, corrupted, short and loose byte streams under random idling
// and output stalls. A scoreboard predicts each reading from the accepted
// bytes and the calibration registers, and compares it field by field.
// ----------------------------------------------------------------------------
module tb_sensor_frame_crc_check_convert;
  timeunit 1ns;
  timeprecision 1ps;

  import sfcc_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;  // cycles with nothing accepted
  localparam int unsigned DRAIN_CYCLES   = 10;    // idle wait after the last reading is checked
  localparam int unsigned PHASE_BYTES    = 280;   // random bytes per register setting
  localparam int unsigned HOLD_CYCLES    = 200;   // one long output stall
  localparam int unsigned HOLD_AT_BYTE   = 150;
  localparam int unsigned CALM_FROM      = 800;   // no idling on either side here
  localparam int unsigned CALM_TO        = 1100;
  localparam int unsigned SHOW_LIMIT     = 10;

  // Q8 conversion constants: 175*256, 45*256, 100*256, full raw scale
  localparam longint TEMP_SPAN_Q8 = 44800;
  localparam longint TEMP_BASE_Q8 = 11520;
  localparam longint HUM_SPAN_Q8  = 25600;
  localparam longint RAW_SCALE    = 65535;
  localparam longint RAW_ROUND    = 32767;
  localparam longint GAIN_ROUND   = 8192;
  localparam logic [7:0] REG_FIRST_UNUSED = 8'(REG_HUM_OFFSET) + 8'd1;

  typedef struct packed {
    logic signed [15:0] temperature;
    logic signed [15:0] humidity;
    logic               ok;
  } reading_t;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the frame state and calibration, queues the readings
  // a frame end produces, and checks them in order.
  // --------------------------------------------------------------------------
  class reading_scoreboard;
    sfcc_cfg_t   cal;
    logic [2:0]  pos;
    logic [7:0]  crc;
    logic [15:0] t_word;
    logic [15:0] h_word;
    logic        crc_good;
    reading_t    readings_due[$];
    int unsigned fails;
    int unsigned shown;

    function new();
      cal.temp_gain   = 16'd16384;
      cal.temp_offset = 16'sd0;
      cal.hum_gain    = 16'd16384;
      cal.hum_offset  = 16'sd0;
      fails = 0;
      shown = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      pos      = 3'd0;
      crc      = CRC_INIT;
      t_word   = 16'd0;
      h_word   = 16'd0;
      crc_good = 1'b1;
    endfunction

    // CRC-8 poly 0x31, MSB first
    function logic [7:0] crc_next(logic [7:0] c, logic [7:0] d);
      logic [7:0] r;
      r = c ^ d;
      for (int i = 0; i < 8; i++) begin
        if (r[7]) r = (r << 1) ^ 8'h31;
        else r = r << 1;
      end
      return r;
    endfunction

    function void write_reg(logic [7:0] idx, logic [15:0] val);
      case (idx)
        REG_TEMP_GAIN:   cal.temp_gain   = val;
        REG_TEMP_OFFSET: cal.temp_offset = val;
        REG_HUM_GAIN:    cal.hum_gain    = val;
        REG_HUM_OFFSET:  cal.hum_offset  = val;
        default: ;
      endcase
    endfunction

    // round(v*gain/2^14) half up, plus offset, saturated
    function logic signed [15:0] calibrate(longint v, logic [15:0] gain,
                                           logic signed [15:0] offs);
      longint p;
      p = v * longint'(gain) + GAIN_ROUND;
      p = (p >>> 14) + longint'(offs);
      if (p > 32767) p = 32767;
      if (p < -32768) p = -32768;
      return p[15:0];
    endfunction

    function void take_byte(logic [7:0] d, logic fin);
      reading_t   r;
      logic [2:0] nxt;
      longint     tv;
      longint     hv;
      if (pos == CRC_POS_T || pos == CRC_POS_H) begin
        if (crc != d) crc_good = 1'b0;
        crc = CRC_INIT;
      end else begin
        crc = crc_next(crc, d);
        if (pos < CRC_POS_T) t_word = {t_word[7:0], d};
        else h_word = {h_word[7:0], d};
      end
      nxt = pos + 3'd1;
      if (nxt < FRAME_BYTES && !fin) begin
        pos = nxt;
        return;
      end
      r = '0;
      r.ok = (nxt == FRAME_BYTES) && crc_good;
      if (r.ok) begin
        tv = (longint'(t_word) * TEMP_SPAN_Q8 + RAW_ROUND) / RAW_SCALE - TEMP_BASE_Q8;
        hv = (longint'(h_word) * HUM_SPAN_Q8 + RAW_ROUND) / RAW_SCALE;
        r.temperature = calibrate(tv, cal.temp_gain, cal.temp_offset);
        r.humidity    = calibrate(hv, cal.hum_gain, cal.hum_offset);
      end
      readings_due.push_back(r);
      clear_frame();
    endfunction

    function void check_reading(logic signed [15:0] t, logic signed [15:0] h, logic ok);
      reading_t want;
      if (readings_due.size() == 0) begin
        fails++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("[%0t] unexpected reading T=%0d H=%0d ok=%0b", $realtime, t, h, ok);
        end
        return;
      end
      want = readings_due.pop_front();
      if (want.temperature !== t || want.humidity !== h || want.ok !== ok) begin
        fails++;
        if (shown < SHOW_LIMIT) begin
          shown++;
          $display("[%0t] reading mismatch: expected T=%0d H=%0d ok=%0b, got T=%0d H=%0d ok=%0b",
                   $realtime, want.temperature, want.humidity, want.ok, t, h, ok);
        end
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, DUT
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  sfcc_in_if  in_ch();
  sfcc_out_if out_ch();
  sfcc_cfg_if cfg_ch();

  sensor_frame_crc_check_convert u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  reading_scoreboard sb;
  int unsigned bytes_in = 0;     // accepted input items so far
  int unsigned quiet = 0;        // cycles since anything was accepted
  bit          hold_done = 1'b0;

  // Window with idling off on both sides, so the block runs back to back.
  function automatic bit calm();
    return bytes_in >= CALM_FROM && bytes_in < CALM_TO;
  endfunction

  // Mostly random words, with both ends of the raw range now and then.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(9))
      0: return 16'h0000;
      1: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Input side. send_item lowers valid only for a random idle before
  // an item, so back-to-back items keep it high.
  // --------------------------------------------------------------------------
  task automatic send_item(input logic [7:0] d, input logic fin);
    if (!calm() && $urandom_range(99) < 9) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 2)) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.rx_byte   <= d;
    in_ch.frame_end <= fin;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.take_byte(d, fin);
    bytes_in++;
  endtask

  // First len bytes of a frame; the CRC bytes are xored with the flip masks
  // to corrupt them. The last byte sent carries fin as its frame_end.
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic [7:0] tflip, input logic [7:0] hflip,
                            input int unsigned len, input logic fin);
    logic [7:0] fb[6];
    logic [7:0] ct;
    logic [7:0] ch;
    ct = sb.crc_next(sb.crc_next(CRC_INIT, tw[15:8]), tw[7:0]);
    ch = sb.crc_next(sb.crc_next(CRC_INIT, hw[15:8]), hw[7:0]);
    fb = '{tw[15:8], tw[7:0], ct ^ tflip, hw[15:8], hw[7:0], ch ^ hflip};
    for (int i = 0; i < len; i++) send_item(fb[i], (i == len - 1) ? fin : 1'b0);
  endtask

  // Mostly whole frames with random words; the rest are bad CRCs, short
  // frames and loose bytes. Loose bytes end with frame_end so the next
  // frame starts aligned again.
  task automatic run_random(input int unsigned target);
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    logic [7:0]  tflip;
    logic [7:0]  hflip;
    start = bytes_in;
    while (bytes_in - start < target) begin
      kind = $urandom_range(99);
      if (kind < 62) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, 6, 1'($urandom_range(1)));
      end else if (kind < 76) begin
        tflip = 8'h00;
        hflip = 8'h00;
        case ($urandom_range(2))
          0: tflip = 8'($urandom_range(1, 255));
          1: hflip = 8'($urandom_range(1, 255));
          default: begin
            tflip = 8'($urandom_range(1, 255));
            hflip = 8'($urandom_range(1, 255));
          end
        endcase
        send_frame(pick_word(), pick_word(), tflip, hflip, 6, 1'($urandom_range(1)));
      end else if (kind < 88) begin
        send_frame(pick_word(), pick_word(), 8'h00, 8'h00, $urandom_range(1, 5), 1'b1);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++)
          send_item(8'($urandom), (i == n - 1) || ($urandom_range(99) < 25));
      end
    end
    in_ch.valid <= 1'b0;
  endtask

  // Register writes; caller drops valid after the last one.
  task automatic write_reg(input logic [7:0] idx, input logic [15:0] val);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    sb.write_reg(idx, val);
  endtask

  task automatic write_all(input logic [15:0] tg, input logic [15:0] to,
                           input logic [15:0] hg, input logic [15:0] ho);
    write_reg(REG_TEMP_GAIN, tg);
    write_reg(REG_TEMP_OFFSET, to);
    write_reg(REG_HUM_GAIN, hg);
    write_reg(REG_HUM_OFFSET, ho);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait for every queued reading, then let the converter pipeline empty
  // (a trailing partial frame produces nothing to wait on).
  task automatic settle();
    while (sb.readings_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Output side: random stalls, one long hold-off while the sender keeps
  // pushing so the frame queue fills and in_ch.ready drops.
  // --------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (!hold_done && bytes_in >= HOLD_AT_BYTE) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      out_ch.ready <= rst_n && (calm() || $urandom_range(99) >= 9);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready)
      sb.check_reading(out_ch.temperature_q8, out_ch.humidity_q8, out_ch.frame_ok);
  end

  // Watchdog on cycles where no channel moves an item.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.rx_byte   = 8'h00;
    in_ch.frame_end = 1'b0;
    cfg_ch.valid    = 1'b0;
    cfg_ch.index    = '0;
    cfg_ch.data     = 16'h0000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed, reset calibration: coldest/wettest and hottest/driest raw
    // values, sixth byte completing a frame without frame_end, a bad
    // temperature CRC, a one-byte frame, and a frame ending after byte five.
    send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 6, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 8'h00, 8'h00, 6, 1'b0);
    send_frame(16'h6666, 16'h8000, 8'h01, 8'h00, 6, 1'b1);
    send_item(8'hA5, 1'b1);
    send_frame(16'h1234, 16'h5678, 8'h00, 8'h00, 5, 1'b1);
    run_random(PHASE_BYTES);
    settle();

    // Full gain and top offsets pin humidity, and every temperature not below zero, at positive saturation.
    // A write to an index past the register map must be dropped.
    write_reg(REG_FIRST_UNUSED + 8'($urandom_range(0, 255 - 4)), 16'($urandom));
    write_all(16'hFFFF, 16'h7FFF, 16'hFFFF, 16'h7FFF);
    run_random(PHASE_BYTES);
    settle();

    // Zero gain and bottom offsets: every good frame pinned at the negative end.
    write_all(16'h0000, 16'h8000, 16'h0000, 16'h8000);
    run_random(PHASE_BYTES);
    settle();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(PHASE_BYTES);
    settle();

    // Unity gain with small shifts, where rounding shows most.
    write_all(16'd16384, 16'($urandom_range(0, 2047)) - 16'd1024,
              16'd16384, 16'($urandom_range(0, 2047)) - 16'd1024);
    run_random(PHASE_BYTES);
    settle();

    write_all(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    run_random(PHASE_BYTES);
    settle();

    if (sb.fails == 0 && sb.readings_due.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/sfcc_pkg.sv
src/sfcc_if.sv
src/sfcc_front.sv
src/sfcc_queue.sv
src/sfcc_back.sv
src/sensor_frame_crc_check_convert.sv
tb/tb_sensor_frame_crc_check_convert.sv
